FILE: hdl/mbb_pkg.sv
package mbb_pkg;

  localparam int ADDR_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd7;

  // pixel format codes
  localparam logic [2:0] FMT_RGBA8   = 3'd0;
  localparam logic [2:0] FMT_RGB8    = 3'd1;
  localparam logic [2:0] FMT_RGB565  = 3'd2;
  localparam logic [2:0] FMT_A1_RGB5 = 3'd3;
  localparam logic [2:0] FMT_RGBA4   = 3'd4;

  // bytes per pixel
  localparam logic [2:0] SIZE_2 = 3'd2;
  localparam logic [2:0] SIZE_3 = 3'd3;
  localparam logic [2:0] SIZE_4 = 3'd4;

  // reset values
  localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd240;
  localparam logic [7:0]  RST_BITMAP_WIDTH  = 8'd8;
  localparam logic [7:0]  RST_BITMAP_HEIGHT = 8'd8;

  typedef struct packed {
    logic [31:0] fb_base;
    logic [11:0] screen_height;
    logic [2:0]  pixel_format;
    logic [31:0] draw_color;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [7:0]  bitmap_width;
    logic [7:0]  bitmap_height;
  } cfg_t;

  // one classified bitmap byte: mask bit b is the pixel at column col_base + b
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] col_base;
    logic [7:0] row;
  } qent_t;

  function automatic logic [2:0] pixel_bytes(input logic [2:0] fmt);
    logic [2:0] sz;
    case (fmt) inside
      FMT_RGBA8:                          sz = SIZE_4;
      FMT_RGB565, FMT_A1_RGB5, FMT_RGBA4: sz = SIZE_2;
      default:                            sz = SIZE_3;
    endcase
    return sz;
  endfunction

endpackage

FILE: hdl/mbb_ifs.sv
interface mbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bitmap_byte;
  logic       first_byte;
  modport source (output valid, bitmap_byte, first_byte, input ready);
  modport sink   (input valid, bitmap_byte, first_byte, output ready);
endinterface

interface mbb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [31:0] write_data;
  logic [2:0]  byte_count;
  logic        last;
  modport source (output valid, write_address, write_data, byte_count, last, input ready);
  modport sink   (input valid, write_address, write_data, byte_count, last, output ready);
endinterface

interface mbb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbb_pkg::CFG_IDX_W-1:0]   index;
  logic [mbb_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/mono_bitmap_blit_rotated_fb_unit.sv
// channel   dir   payload                                            accepted when
// in_ch     in    bitmap_byte[7:0], first_byte                       valid && ready
// out_ch    out   write_address[31:0], write_data[31:0],
//                 byte_count[2:0], last                              valid && ready
// cfg_ch    in    index[2:0], data[31:0]                             valid && ready
//
// a bitmap byte gives one write word per pixel it draws (1 to 8), none if it draws nothing;
// one word leaves the back end's single write port per cycle unless the output stalls
// bytes pass a four-entry queue, the pixel picker, the address stages and the output
// word; the queue lets the front keep taking bytes while the back end works
// reset (rst_n low, synchronous) clears position, queue, pipeline and config defaults
// a stalled output word holds the whole back end; the front stalls only on a full queue
module mono_bitmap_blit_rotated_fb_unit #(
  parameter int ADDR_WIDTH = mbb_pkg::ADDR_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mbb_in_if.sink    in_ch,
  mbb_out_if.source out_ch,
  mbb_cfg_if.sink   cfg_ch
);

  // configuration registers
  mbb_pkg::cfg_t cfg_r, cfg_nxt;

  // front to back queue
  logic           q_push, q_full, q_pop, q_empty;
  mbb_pkg::qent_t q_wdata, q_head;

  // config port never stalls
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mbb_pkg::REG_FB_BASE:       cfg_nxt.fb_base       = cfg_ch.data;
        mbb_pkg::REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_ch.data[11:0];
        mbb_pkg::REG_PIXEL_FORMAT:  cfg_nxt.pixel_format  = cfg_ch.data[2:0];
        mbb_pkg::REG_DRAW_COLOR:    cfg_nxt.draw_color    = cfg_ch.data;
        mbb_pkg::REG_ORIGIN_X:      cfg_nxt.origin_x      = cfg_ch.data[11:0];
        mbb_pkg::REG_ORIGIN_Y:      cfg_nxt.origin_y      = cfg_ch.data[11:0];
        mbb_pkg::REG_BITMAP_WIDTH:  cfg_nxt.bitmap_width  = cfg_ch.data[7:0];
        mbb_pkg::REG_BITMAP_HEIGHT: cfg_nxt.bitmap_height = cfg_ch.data[7:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_base       <= '0;
      cfg_r.screen_height <= mbb_pkg::RST_SCREEN_HEIGHT;
      cfg_r.pixel_format  <= mbb_pkg::FMT_RGBA8;
      cfg_r.draw_color    <= '0;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.bitmap_width  <= mbb_pkg::RST_BITMAP_WIDTH;
      cfg_r.bitmap_height <= mbb_pkg::RST_BITMAP_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // byte classification and bitmap position tracking
  mbb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  mbb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // per-pixel address pipeline and output word
  mbb_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: hdl/mbb_front.sv
module mbb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  mbb_pkg::cfg_t  cfg,
  mbb_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output mbb_pkg::qent_t q_data
);

  logic [4:0] bc_r, bc_nxt;
  logic [7:0] row_r, row_nxt;

  logic       acc;
  logic [4:0] bc0;
  logic [7:0] row0;
  logic       skip;
  logic [7:0] mask;
  logic [7:0] col;
  logic [5:0] row_bytes;
  logic [4:0] bc_inc;
  logic [7:0] row_inc;

  assign in_ch.ready = !q_full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign bc0  = in_ch.first_byte ? 5'd0 : bc_r;
  assign row0 = in_ch.first_byte ? 8'd0 : row_r;
  assign skip = (cfg.bitmap_width == 8'd0) || (cfg.bitmap_height == 8'd0)
             || (row0 >= cfg.bitmap_height);
  assign row_bytes = 6'(({1'b0, cfg.bitmap_width} + 9'd7) >> 3);
  assign bc_inc  = bc0 + 5'd1;
  assign row_inc = row0 + 8'd1;

  // bit b of the mask is the pixel b places right of the byte's left edge
  always_comb begin
    mask = '0;
    col  = '0;
    for (int b = 0; b < 8; b++) begin
      col     = {bc0, 3'(b)};
      mask[b] = in_ch.bitmap_byte[7-b] && (col < cfg.bitmap_width);
    end
  end

  always_comb begin
    bc_nxt  = bc_r;
    row_nxt = row_r;
    if (acc) begin
      bc_nxt  = bc0;
      row_nxt = row0;
      if (!skip) begin
        if (({1'b0, bc_inc} >= row_bytes) || (bc_inc == 5'd0)) begin
          bc_nxt  = 5'd0;
          // row counter sticks at the top instead of wrapping to row 0
          row_nxt = (row_inc == 8'd0) ? 8'hFF : row_inc;
        end else begin
          bc_nxt = bc_inc;
        end
      end
    end
  end

  assign q_push          = acc && !skip && (mask != 8'd0);
  assign q_data.mask     = mask;
  assign q_data.col_base = {bc0, 3'd0};
  assign q_data.row      = row0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r  <= '0;
      row_r <= '0;
    end else begin
      bc_r  <= bc_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: hdl/mbb_fifo.sv
module mbb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbb_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mbb_pkg::qent_t head
);

  localparam int D  = mbb_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(D - 1);

  mbb_pkg::qent_t mem_r [D];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(D));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hdl/mbb_back.sv
module mbb_back #(
  parameter int ADDR_WIDTH = mbb_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mbb_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  mbb_pkg::qent_t q_head,
  output logic           q_pop,
  mbb_out_if.source      out_ch
);

  localparam int AW = ADDR_WIDTH;

  // whole pipeline moves together; it holds only while the output word waits
  logic en;

  // pixel picker
  logic [7:0] cur_mask_r, cur_mask_nxt;
  logic [7:0] cur_col_r, cur_col_nxt;
  logic [7:0] cur_row_r, cur_row_nxt;
  logic       has;
  logic [2:0] pick;
  logic [7:0] rest;

  // stage 1: screen coordinates
  logic        s1_valid_r;
  logic [12:0] s1_px_r, s1_py_r;
  logic        s1_last_r;
  // stage 2: column offset product and row offset
  logic        s2_valid_r;
  logic [24:0] s2_prod_r;
  logic [AW-1:0] s2_off_r;
  logic        s2_last_r;
  // stage 3: pixel index
  logic        s3_valid_r;
  logic [AW-1:0] s3_idx_r;
  logic        s3_last_r;
  // stage 4: byte offset
  logic        s4_valid_r;
  logic [AW-1:0] s4_ofs_r;
  logic        s4_last_r;
  // output word
  logic        o_valid_r;
  logic [31:0] o_addr_r;
  logic [31:0] o_data_r;
  logic [2:0]  o_cnt_r;
  logic        o_last_r;

  logic [2:0]    size;
  logic [31:0]   color;
  logic [AW-1:0] scaled;

  assign en   = !o_valid_r || out_ch.ready;
  assign has  = (cur_mask_r != 8'd0);
  assign size = mbb_pkg::pixel_bytes(cfg.pixel_format);

  // leftmost pending pixel first
  always_comb begin
    pick = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (cur_mask_r[b]) begin
        pick = 3'(b);
      end
    end
  end

  assign rest = has ? (cur_mask_r & ~(8'd1 << pick)) : 8'd0;

  always_comb begin
    cur_mask_nxt = cur_mask_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    q_pop        = 1'b0;
    if (en || !has) begin
      if (rest == 8'd0 && !q_empty) begin
        cur_mask_nxt = q_head.mask;
        cur_col_nxt  = q_head.col_base;
        cur_row_nxt  = q_head.row;
        q_pop        = 1'b1;
      end else begin
        cur_mask_nxt = rest;
      end
    end
  end

  always_comb begin
    case (size)
      mbb_pkg::SIZE_4: scaled = s3_idx_r << 2;
      mbb_pkg::SIZE_2: scaled = s3_idx_r << 1;
      default:         scaled = (s3_idx_r << 1) + s3_idx_r;
    endcase
  end

  always_comb begin
    case (size)
      mbb_pkg::SIZE_4: color = cfg.draw_color;
      mbb_pkg::SIZE_2: color = {16'd0, cfg.draw_color[15:0]};
      default:         color = {8'd0, cfg.draw_color[23:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      cur_mask_r <= cur_mask_nxt;
      if (en) begin
        s1_valid_r <= has;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        s4_valid_r <= s3_valid_r;
        o_valid_r  <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_col_r <= cur_col_nxt;
    cur_row_r <= cur_row_nxt;
    if (en) begin
      s1_px_r   <= 13'(cfg.origin_x) + 13'({cur_col_r[7:3], pick});
      s1_py_r   <= 13'(cfg.origin_y) + 13'(cur_row_r);
      s1_last_r <= (rest == 8'd0);

      s2_prod_r <= 25'(s1_px_r) * 25'(cfg.screen_height);
      s2_off_r  <= AW'(cfg.screen_height) - AW'(1) - AW'(s1_py_r);
      s2_last_r <= s1_last_r;

      s3_idx_r  <= AW'(s2_prod_r) + s2_off_r;
      s3_last_r <= s2_last_r;

      s4_ofs_r  <= scaled;
      s4_last_r <= s3_last_r;

      o_addr_r  <= 32'(AW'(cfg.fb_base) + s4_ofs_r);
      o_data_r  <= color;
      o_cnt_r   <= size;
      o_last_r  <= s4_last_r;
    end
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.write_address = o_addr_r;
  assign out_ch.write_data    = o_data_r;
  assign out_ch.byte_count    = o_cnt_r;
  assign out_ch.last          = o_last_r;

endmodule

FILE: verif/mono_bitmap_blit_rotated_fb_unit_tb.sv
module mono_bitmap_blit_rotated_fb_unit_tb;

  // cycles with no word moving on any channel before the run is called hung
  localparam int STALL_LIMIT   = 5000;
  // the block holds bytes in a four-entry queue ahead of its address pipeline;
  // after the expected writes drain, give it a generous margin
  localparam int SETTLE_CYCLES = 24;
  localparam int RAND_SEGMENTS = 8;
  localparam int SEG_BYTES     = 10;
  localparam int MAX_PRINTS    = 40;

  // one framebuffer write as it leaves the block
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } fb_write_t;

  // one row of the directed table: a register write or a bitmap byte
  typedef struct {
    logic        is_reg;
    logic [2:0]  idx;
    logic [31:0] val;
    logic [7:0]  bm;
    logic        first_b;
    logic        typed;        // expectation written into the table
    logic        typed_draws;  // typed row draws exactly one pixel
    fb_write_t   typed_write;
  } plan_row_t;

  logic clk;
  logic rst_n;

  mbb_in_if  in_ch  ();
  mbb_out_if out_ch ();
  mbb_cfg_if cfg_ch ();

  mono_bitmap_blit_rotated_fb_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow registers
  logic [31:0] c_base;
  logic [11:0] c_height;
  logic [2:0]  c_fmt;
  logic [31:0] c_color;
  logic [11:0] c_ox;
  logic [11:0] c_oy;
  logic [7:0]  c_bm_w;
  logic [7:0]  c_bm_h;

  // bitmap position
  logic [4:0]  byte_col;
  logic [7:0]  row_idx;
  logic        byte_taken;

  fb_write_t   pending_writes [$];
  plan_row_t   plan [$];

  int mismatches     = 0;
  int writes_checked = 0;
  int bytes_sent     = 0;
  int directed_bytes = 0;
  int reg_writes     = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  // predicted writes for one bitmap byte; advances the shadow position
  function automatic int plot_pixels(input logic [7:0] bm, input logic first_b,
                                     output fb_write_t w [8]);
    int          n;
    logic [31:0] row_bytes;
    logic [2:0]  nb;
    logic [31:0] color;
    logic [31:0] col;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] h;
    logic [31:0] idx;
    n = 0;
    byte_taken = 1'b0;
    for (int k = 0; k < 8; k++) w[k] = '0;
    if (first_b) begin
      byte_col = '0;
      row_idx  = '0;
    end
    // empty bitmap, or past its last row: nothing drawn, position held
    if (c_bm_w == 0 || c_bm_h == 0 || row_idx >= c_bm_h) return 0;
    byte_taken = 1'b1;
    row_bytes = (32'(c_bm_w) + 32'd7) >> 3;
    case (c_fmt) inside
      mbb_pkg::FMT_RGBA8: nb = mbb_pkg::SIZE_4;
      mbb_pkg::FMT_RGB565, mbb_pkg::FMT_A1_RGB5, mbb_pkg::FMT_RGBA4:
        nb = mbb_pkg::SIZE_2;
      default: nb = mbb_pkg::SIZE_3;
    endcase
    color = (nb == mbb_pkg::SIZE_4) ? c_color
                                    : (c_color & ((32'd1 << (32'(nb) * 8)) - 32'd1));
    h = 32'(c_height);
    for (int b = 0; b < 8; b++) begin
      col = 32'(byte_col) * 8 + 32'(b);
      // padding bits past the width are dropped
      if (col < 32'(c_bm_w) && bm[7 - b]) begin
        px = 32'(c_ox) + col;
        py = 32'(c_oy) + 32'(row_idx);
        idx = px * h + h - 32'd1 - py;
        w[n].addr   = c_base + idx * 32'(nb);
        w[n].data   = color;
        w[n].nbytes = nb;
        w[n].last   = 1'b0;
        n++;
      end
    end
    if (n > 0) w[n - 1].last = 1'b1;
    byte_col = byte_col + 5'd1;
    if (32'(byte_col) >= row_bytes || byte_col == 0) begin
      byte_col = '0;
      row_idx  = row_idx + 8'd1;
      if (row_idx == 0) row_idx = 8'hFF;
    end
    return n;
  endfunction

  // table builders
  function automatic void add_reg(input logic [2:0] idx, input logic [31:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] bm, input logic first_b);
    plan_row_t r;
    r = '{default: '0};
    r.bm      = bm;
    r.first_b = first_b;
    plan.push_back(r);
  endfunction

  function automatic void add_byte_none(input logic [7:0] bm, input logic first_b);
    plan_row_t r;
    r = '{default: '0};
    r.bm      = bm;
    r.first_b = first_b;
    r.typed   = 1'b1;
    plan.push_back(r);
  endfunction

  function automatic void add_byte_one(input logic [7:0] bm, input logic first_b,
                                       input logic [31:0] addr, input logic [31:0] data,
                                       input logic [2:0] nbytes);
    plan_row_t r;
    r = '{default: '0};
    r.bm          = bm;
    r.first_b     = first_b;
    r.typed       = 1'b1;
    r.typed_draws = 1'b1;
    r.typed_write = '{addr: addr, data: data, nbytes: nbytes, last: 1'b1};
    plan.push_back(r);
  endfunction

  // one register word; valid stays up so back-to-back writes need no gap
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      mbb_pkg::REG_FB_BASE:       c_base   = val;
      mbb_pkg::REG_SCREEN_HEIGHT: c_height = val[11:0];
      mbb_pkg::REG_PIXEL_FORMAT:  c_fmt    = val[2:0];
      mbb_pkg::REG_DRAW_COLOR:    c_color  = val;
      mbb_pkg::REG_ORIGIN_X:      c_ox     = val[11:0];
      mbb_pkg::REG_ORIGIN_Y:      c_oy     = val[11:0];
      mbb_pkg::REG_BITMAP_WIDTH:  c_bm_w   = val[7:0];
      mbb_pkg::REG_BITMAP_HEIGHT: c_bm_h   = val[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // one bitmap word, with an optional random idle gap in front of it
  task automatic send_byte(input logic [7:0] bm, input logic first_b, input logic typed,
                           input logic typed_draws, input fb_write_t typed_write);
    int        gap;
    int        n;
    fb_write_t calc [8];
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.bitmap_byte <= bm;
    in_ch.first_byte  <= first_b;
    do @(posedge clk); while (!in_ch.ready);
    n = plot_pixels(bm, first_b, calc);
    if (typed) begin
      if (typed_draws) pending_writes.push_back(typed_write);
    end else begin
      for (int i = 0; i < n; i++) pending_writes.push_back(calc[i]);
    end
    bytes_sent++;
  endtask

  // stop feeding, let every expected write drain, then let the pipe settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one random setting per segment, pulled toward small bitmaps
  task automatic randomize_regs();
    logic [31:0] h;
    logic [31:0] bw;
    logic [31:0] bh;
    case ($urandom_range(7))
      0:       h = 32'd0;
      1:       h = 32'd4095;
      2:       h = 32'd1;
      default: h = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(9))
      0:       bw = 32'd0;
      1:       bw = 32'd255;
      default: bw = $urandom_range(1, 24);
    endcase
    case ($urandom_range(9))
      0:       bh = 32'd0;
      1:       bh = 32'd255;
      default: bh = $urandom_range(1, 4);
    endcase
    write_reg(mbb_pkg::REG_FB_BASE, $urandom);
    write_reg(mbb_pkg::REG_SCREEN_HEIGHT, h);
    write_reg(mbb_pkg::REG_PIXEL_FORMAT, $urandom_range(7));
    write_reg(mbb_pkg::REG_DRAW_COLOR, $urandom);
    write_reg(mbb_pkg::REG_ORIGIN_X, $urandom_range(4095));
    write_reg(mbb_pkg::REG_ORIGIN_Y, $urandom_range(4095));
    write_reg(mbb_pkg::REG_BITMAP_WIDTH, bw);
    write_reg(mbb_pkg::REG_BITMAP_HEIGHT, bh);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver: ready drawn fresh each cycle from the current stall rate
  always @(posedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // result checker: each write word against the oldest expectation
  always @(posedge clk) begin : write_check
    fb_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) begin
        flag_mismatch("write with nothing pending, addr", out_ch.write_address, '0);
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.write_address !== want.addr)
          flag_mismatch("write_address", out_ch.write_address, want.addr);
        if (out_ch.write_data !== want.data)
          flag_mismatch("write_data", out_ch.write_data, want.data);
        if (out_ch.byte_count !== want.nbytes)
          flag_mismatch("byte_count", 32'(out_ch.byte_count), 32'(want.nbytes));
        if (out_ch.last !== want.last)
          flag_mismatch("last", 32'(out_ch.last), 32'(want.last));
        writes_checked++;
      end
    end
  end

  // watchdog: any word on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d writes pending",
               quiet_cycles, pending_writes.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t r;
    logic      prev_reg;
    logic      restart;
    int        sent;
    int        used;
    int        left;

    // every input known from time zero
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.bitmap_byte <= '0;
    in_ch.first_byte  <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;

    // shadow of the reset state
    c_base   = '0;
    c_height = mbb_pkg::RST_SCREEN_HEIGHT;
    c_fmt    = mbb_pkg::FMT_RGBA8;
    c_color  = '0;
    c_ox     = '0;
    c_oy     = '0;
    c_bm_w   = mbb_pkg::RST_BITMAP_WIDTH;
    c_bm_h   = mbb_pkg::RST_BITMAP_HEIGHT;
    byte_col = '0;
    row_idx  = '0;

    // directed table
    // reset defaults: 8x8 bitmap, column of 240, four-byte pixels, colour zero
    add_byte_one(8'h80, 1'b1, 32'h0000_03BC, 32'h0, mbb_pkg::SIZE_4);
    add_byte_none(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    // every register but the pixel format at its top value: addresses wrap past 2^32
    add_reg(mbb_pkg::REG_FB_BASE,       32'hFFFF_FFFF);
    add_reg(mbb_pkg::REG_SCREEN_HEIGHT, 32'd4095);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT,  32'(mbb_pkg::FMT_RGBA4));
    add_reg(mbb_pkg::REG_DRAW_COLOR,    32'hFFFF_FFFF);
    add_reg(mbb_pkg::REG_ORIGIN_X,      32'd4095);
    add_reg(mbb_pkg::REG_ORIGIN_Y,      32'd4095);
    add_reg(mbb_pkg::REG_BITMAP_WIDTH,  32'd255);
    add_reg(mbb_pkg::REG_BITMAP_HEIGHT, 32'd255);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h5A, 1'b0);
    // width shrinks mid-row: the byte position is already past the row
    add_reg(mbb_pkg::REG_BITMAP_WIDTH, 32'd8);
    add_byte_none(8'hFF, 1'b0);
    add_byte(8'h81, 1'b0);
    // unknown format codes fall back to three-byte pixels
    add_reg(mbb_pkg::REG_FB_BASE,       32'h0);
    add_reg(mbb_pkg::REG_SCREEN_HEIGHT, 32'd1);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT,  32'd7);
    add_reg(mbb_pkg::REG_DRAW_COLOR,    32'h1122_3344);
    add_reg(mbb_pkg::REG_ORIGIN_X,      32'd0);
    add_reg(mbb_pkg::REG_ORIGIN_Y,      32'd0);
    add_byte_one(8'h80, 1'b1, 32'h0, 32'h0022_3344, mbb_pkg::SIZE_3);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT, 32'd5);
    add_byte(8'h7F, 1'b0);
    // zero screen height: height - 1 wraps
    add_reg(mbb_pkg::REG_SCREEN_HEIGHT, 32'd0);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT,  32'(mbb_pkg::FMT_RGBA8));
    add_byte_one(8'h80, 1'b1, 32'hFFFF_FFFC, 32'h1122_3344, mbb_pkg::SIZE_4);
    // three-wide single row: padding bits, then bytes past the bitmap
    add_reg(mbb_pkg::REG_SCREEN_HEIGHT, 32'd240);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT,  32'(mbb_pkg::FMT_RGB8));
    add_reg(mbb_pkg::REG_BITMAP_WIDTH,  32'd3);
    add_reg(mbb_pkg::REG_BITMAP_HEIGHT, 32'd1);
    add_byte(8'hFF, 1'b1);
    add_byte_none(8'hFF, 1'b0);
    add_byte_none(8'hFF, 1'b0);
    add_byte(8'h20, 1'b1);
    // empty bitmaps
    add_reg(mbb_pkg::REG_BITMAP_WIDTH, 32'd0);
    add_byte_none(8'hFF, 1'b1);
    add_reg(mbb_pkg::REG_BITMAP_WIDTH,  32'd8);
    add_reg(mbb_pkg::REG_BITMAP_HEIGHT, 32'd0);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT,  32'(mbb_pkg::FMT_A1_RGB5));
    add_byte_none(8'hFF, 1'b1);
    // 12x2 bitmap, two bytes a row
    add_reg(mbb_pkg::REG_BITMAP_WIDTH,  32'd12);
    add_reg(mbb_pkg::REG_BITMAP_HEIGHT, 32'd2);
    add_reg(mbb_pkg::REG_PIXEL_FORMAT,  32'(mbb_pkg::FMT_RGB565));
    add_reg(mbb_pkg::REG_ORIGIN_X,      32'd100);
    add_reg(mbb_pkg::REG_ORIGIN_Y,      32'd50);
    add_reg(mbb_pkg::REG_FB_BASE,       32'h1000_0000);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hF0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h0F, 1'b0);
    add_byte_none(8'h01, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the table; registers only change once the block has gone quiet
    prev_reg = 1'b0;
    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_reg) begin
        if (!prev_reg) wait_idle();
        write_reg(r.idx, r.val);
      end else begin
        if (prev_reg) cfg_ch.valid <= 1'b0;
        send_byte(r.bm, r.first_b, r.typed, r.typed_draws, r.typed_write);
      end
      prev_reg = r.is_reg;
    end
    directed_bytes = bytes_sent;

    // random segments: mostly whole bitmaps from first_byte on, with some
    // stray restarts and runs past the end; two segments per idling mode
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      wait_idle();
      case (seg / 2)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      randomize_regs();
      sent = 0;
      used = 0;
      left = 0;
      while (used < SEG_BYTES && sent < SEG_BYTES + 4) begin
        if (sent == 0)
          restart = ($urandom_range(3) != 0);  // sometimes carry the old position
        else
          restart = (left == 0 && $urandom_range(11) != 0) || ($urandom_range(11) == 0);
        if (restart) left = ((int'(c_bm_w) + 7) / 8) * int'(c_bm_h);
        send_byte(8'($urandom_range(255)), restart, 1'b0, 1'b0, '0);
        if (left > 0) left--;
        sent++;
        if (byte_taken) used++;
      end
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    wait_idle();

    $display("sent %0d bitmap bytes (%0d directed) over %0d register writes",
             bytes_sent, directed_bytes, reg_writes);
    $display("checked %0d framebuffer writes across four idling modes", writes_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
